@@ hw/rtl/wsc_pkg.sv @@
// ----------------------------------------------------------------------------
// wsc_pkg: shared definitions of the window span cursor
// Widths, span limit and the structs passed between the sequencer and the
// span unit.
// ----------------------------------------------------------------------------
package wsc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int LEN_BITS      = COORD_BITS + 1;
    localparam int COLOR_BITS    = 32;
    localparam int COUNT_BITS    = 24;
    localparam int MAX_SPANS     = 64;
    localparam int SPAN_CNT_BITS = $clog2(MAX_SPANS + 1);

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS + COUNT_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + LEN_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // command codes carried in s_tuser
    localparam logic CMD_SET_WINDOW = 1'b0;
    localparam logic CMD_WRITE      = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } win_t;

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COUNT_BITS-1:0] rem;
    } span_req_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]   len;
        coord_t                x_next;
        coord_t                y_next;
        logic [COUNT_BITS-1:0] rem_next;
        logic                  done;
    } span_res_t;

endpackage

@@ hw/rtl/wsc_span_unit.sv @@
// ----------------------------------------------------------------------------
// wsc_span_unit: span length and cursor step
// Works out one span from the cursor and the remaining count, and the
// cursor position after it, wrapping at the right and bottom edges.
// ----------------------------------------------------------------------------
module wsc_span_unit (
    input  wsc_pkg::win_t      win,
    input  wsc_pkg::span_req_t req,
    output wsc_pkg::span_res_t res
);
    import wsc_pkg::*;

    logic [LEN_BITS-1:0] room;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] x_sum;
    logic [LEN_BITS-1:0] y_inc;
    logic                x_wrap;
    logic                y_wrap;

    // clip the span to the room left on the row
    assign room = {1'b0, win.right} + LEN_BITS'(1) - {1'b0, req.x};
    assign len  = (req.rem < COUNT_BITS'(room)) ? req.rem[LEN_BITS-1:0] : room;

    // advance the cursor, wrapping to the next row and then to the top
    assign x_sum  = {1'b0, req.x} + len;
    assign x_wrap = x_sum > {1'b0, win.right};
    assign y_inc  = {1'b0, req.y} + LEN_BITS'(1);
    assign y_wrap = y_inc > {1'b0, win.bottom};

    always_comb begin
        res.len      = len;
        res.x_next   = x_wrap ? win.left : x_sum[COORD_BITS-1:0];
        res.y_next   = x_wrap ? (y_wrap ? win.top : y_inc[COORD_BITS-1:0]) : req.y;
        res.rem_next = req.rem - COUNT_BITS'(len);
        res.done     = (req.rem - COUNT_BITS'(len)) == '0;
    end

endmodule

@@ hw/rtl/window_span_cursor.sv @@
// ----------------------------------------------------------------------------
// window_span_cursor: display write-window cursor emitting spans
// Stores the write window and cursor, and breaks each pixel write into
// horizontal spans, one span per cycle while m_tready holds, up to the span limit.
// ----------------------------------------------------------------------------
// Timing: a write request is taken in ST_IDLE; in ST_EMIT its spans are
// loaded into the output register one a cycle while m_tready holds.
// Occupancy: no new request is taken until the last span of a write has been
// loaded, as s_tready is high only in ST_IDLE; spans go through the shared span
// unit. Set-window requests and writes to an empty window leave it in ST_IDLE.
// Reset: aresetn clears window and cursor to zero (a 1x1 window at 0,0)
// and empties the output register.
module window_span_cursor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // win_x_start, win_y_start, win_x_end, win_y_end, pixel_color, pixel_count
    input  logic [wsc_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // span_x, span_y, span_len, span_color, zero padding
    output logic [wsc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                               m_tlast,
    // truncated
    output logic [0:0]                         m_tuser
);
    import wsc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int XS_LO = 0;
    localparam int YS_LO = COORD_BITS;
    localparam int XE_LO = 2 * COORD_BITS;
    localparam int YE_LO = 3 * COORD_BITS;
    localparam int CL_LO = 4 * COORD_BITS;
    localparam int CN_LO = 4 * COORD_BITS + COLOR_BITS;

    logic                     state_reg;
    win_t                     win_reg;
    coord_t                   cur_x_reg;
    coord_t                   cur_y_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [COLOR_BITS-1:0]    color_reg;
    logic [SPAN_CNT_BITS-1:0] cnt_reg;

    logic                     out_valid_reg;
    coord_t                   out_x_reg;
    coord_t                   out_y_reg;
    logic [LEN_BITS-1:0]      out_len_reg;
    logic [COLOR_BITS-1:0]    out_color_reg;
    logic                     out_last_reg;
    logic                     out_trunc_reg;

    span_req_t                req;
    span_res_t                res;
    win_t                     in_win;
    logic                     in_accept;
    logic                     win_empty;
    logic                     load;
    logic                     cut;

    // unpack the request
    assign in_win.left   = s_tdata[XS_LO +: COORD_BITS];
    assign in_win.top    = s_tdata[YS_LO +: COORD_BITS];
    assign in_win.right  = s_tdata[XE_LO +: COORD_BITS];
    assign in_win.bottom = s_tdata[YE_LO +: COORD_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign win_empty = (win_reg.right < win_reg.left) || (win_reg.bottom < win_reg.top);

    // shared span unit
    assign req.x   = cur_x_reg;
    assign req.y   = cur_y_reg;
    assign req.rem = rem_reg;

    wsc_span_unit u_span (
        .win (win_reg),
        .req (req),
        .res (res)
    );

    // produce a span whenever the output register is free or being drained
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign cut  = !res.done && (cnt_reg == SPAN_CNT_BITS'(MAX_SPANS - 1));

    // sequencer and cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_reg   <= '0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end else if (in_accept) begin
            if (s_tuser[0] == CMD_SET_WINDOW) begin
                win_reg   <= in_win;
                cur_x_reg <= in_win.left;
                cur_y_reg <= in_win.top;
            end else if (!win_empty) begin
                state_reg <= ST_EMIT;
            end
        end else if (load) begin
            cur_x_reg <= res.x_next;
            cur_y_reg <= res.y_next;
            if (res.done || cut) begin
                state_reg <= ST_IDLE;
            end
        end
    end

    // hold the write count, colour and span number
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rem_reg   <= s_tdata[CN_LO +: COUNT_BITS];
            color_reg <= s_tdata[CL_LO +: COLOR_BITS];
            cnt_reg   <= '0;
        end else if (load) begin
            rem_reg <= res.rem_next;
            cnt_reg <= cnt_reg + SPAN_CNT_BITS'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_len_reg   <= res.len;
            out_color_reg <= color_reg;
            out_last_reg  <= res.done || cut;
            out_trunc_reg <= cut;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_DATA_BITS'({out_color_reg, out_len_reg, out_y_reg, out_x_reg});
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_trunc_reg;

`ifndef ASSERT_OFF
    // a truncated span is always the final span of its write
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("truncated span without last");

    // a span that is not the last must run to the right window edge
    a_span_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
        ({1'b0, out_x_reg} + out_len_reg) == ({1'b0, win_reg.right} + LEN_BITS'(1)))
        else $error("intermediate span stops short of the right edge");

    // when idle with a usable window, the cursor lies inside it
    a_cursor_in: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && !win_empty |->
        cur_x_reg >= win_reg.left && cur_x_reg <= win_reg.right &&
        cur_y_reg >= win_reg.top && cur_y_reg <= win_reg.bottom)
        else $error("cursor outside the window");

    // the span counter never reaches the limit while spans are produced
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> cnt_reg < SPAN_CNT_BITS'(MAX_SPANS))
        else $error("span counter beyond limit");
`endif

endmodule

@@ tb/span_checker.sv @@
// ----------------------------------------------------------------------------
// span_checker: scoreboard for the window span cursor
// Watches both stream channels, predicts the spans of every accepted request
// from its own copy of window and cursor, and compares each span taken from
// the block, field by field, with the oldest span still due.
// ----------------------------------------------------------------------------
module span_checker
    import wsc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // win_x_start, win_y_start, win_x_end, win_y_end, pixel_color, pixel_count
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // cmd
    input  logic [0:0]               s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // span_x, span_y, span_len, span_color, zero padding
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic                     m_tlast,
    // truncated
    input  logic [0:0]               m_tuser,
    output int                       fail_count,
    output int                       spans_due
);

    typedef struct {
        coord_t                x;
        coord_t                y;
        logic [LEN_BITS-1:0]   len;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  truncated;
    } span_t;

    span_t       due_spans[$];
    win_t        win;
    int unsigned cur_x;
    int unsigned cur_y;

    initial begin
        fail_count = 0;
        spans_due  = 0;
    end

    // Report one field that differs from the expected span
    function automatic void check_field(input string name,
                                        input logic [COLOR_BITS-1:0] want,
                                        input logic [COLOR_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Update window and cursor; queue the spans a pixel write produces
    task automatic predict_spans(input logic cmd, input logic [IN_DATA_BITS-1:0] data);
        int unsigned           remaining;
        int unsigned           room;
        int unsigned           len;
        int unsigned           x;
        int unsigned           y;
        int                    n;
        logic [COLOR_BITS-1:0] color;
        span_t                 sp;
        bit                    done;
        bit                    cut;
        if (cmd == CMD_SET_WINDOW) begin
            win.left   = data[0 +: COORD_BITS];
            win.top    = data[COORD_BITS +: COORD_BITS];
            win.right  = data[2*COORD_BITS +: COORD_BITS];
            win.bottom = data[3*COORD_BITS +: COORD_BITS];
            cur_x      = 32'(win.left);
            cur_y      = 32'(win.top);
        end else if (win.right >= win.left && win.bottom >= win.top) begin
            color     = data[4*COORD_BITS +: COLOR_BITS];
            remaining = 32'(data[4*COORD_BITS+COLOR_BITS +: COUNT_BITS]);
            x         = cur_x;
            y         = cur_y;
            n         = 0;
            do begin
                // run to the right edge or to the end of the count
                room     = 32'(win.right) + 1 - x;
                len      = (remaining < room) ? remaining : room;
                sp.x     = coord_t'(x);
                sp.y     = coord_t'(y);
                sp.len   = LEN_BITS'(len);
                sp.color = color;
                n++;
                x += len;
                if (x > 32'(win.right)) begin
                    x = 32'(win.left);
                    y++;
                    if (y > 32'(win.bottom)) begin
                        y = 32'(win.top);
                    end
                end
                remaining -= len;
                done         = (remaining == 0);
                cut          = !done && (n >= MAX_SPANS);
                sp.last      = done || cut;
                sp.truncated = cut;
                due_spans.push_back(sp);
            end while (!(done || cut));
            cur_x = x;
            cur_y = y;
        end
    endtask

    // Predict on each accepted request, compare each accepted span
    always @(posedge aclk) begin
        span_t sp;
        if (!aresetn) begin
            win = '0;
            cur_x = 0;
            cur_y = 0;
            due_spans.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_spans(s_tuser[0], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (due_spans.size() == 0) begin
                    $display("%0t: span with none expected: expected nothing, actual %0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    sp = due_spans.pop_front();
                    check_field("span_x", COLOR_BITS'(sp.x),
                                COLOR_BITS'(m_tdata[0 +: COORD_BITS]));
                    check_field("span_y", COLOR_BITS'(sp.y),
                                COLOR_BITS'(m_tdata[COORD_BITS +: COORD_BITS]));
                    check_field("span_len", COLOR_BITS'(sp.len),
                                COLOR_BITS'(m_tdata[2*COORD_BITS +: LEN_BITS]));
                    check_field("span_color", sp.color,
                                m_tdata[2*COORD_BITS+LEN_BITS +: COLOR_BITS]);
                    check_field("last", COLOR_BITS'(sp.last), COLOR_BITS'(m_tlast));
                    check_field("truncated", COLOR_BITS'(sp.truncated),
                                COLOR_BITS'(m_tuser[0]));
                end
            end
        end
        spans_due <= due_spans.size();
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the window span cursor
// Drives set-window and pixel-write requests in random bursts, stalls the
// span channel on changing patterns, and leaves prediction and comparison
// to span_checker. Directed corner cases come first, then random traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import wsc_pkg::*;

    localparam int RANDOM_ITEMS = 137;
    localparam int SETTLE_CYCLES = 16;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // receiver stall patterns
    localparam int READY_ALWAYS  = 0;
    localparam int READY_HALF    = 1;
    localparam int READY_SPARSE  = 2;
    localparam int READY_PATTERN = 3;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [0:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic [0:0]               m_tuser;

    int          fail_count;
    int          spans_due;
    int          burst_left = 0;
    int unsigned live_items = 0;
    int          ready_mode = READY_ALWAYS;
    int          ready_left = 0;
    int unsigned cycle_cnt  = 0;

    window_span_cursor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    span_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .spans_due  (spans_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the span channel, switching pattern at random
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(READY_ALWAYS, READY_PATTERN);
            ready_left <= $urandom_range(8, 80);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            READY_HALF: begin
                m_tready <= ($urandom_range(0, 1) == 1);
            end
            READY_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= (cycle_cnt[2:0] != 3'd0) && (cycle_cnt[2:0] != 3'd5);
            end
        endcase
    end

    // Unused fields carry random junk, which the block must ignore
    function automatic logic [IN_DATA_BITS-1:0] random_payload();
        return IN_DATA_BITS'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    // Hand over one request; at the end of a burst, pick the next and a random gap
    task automatic push_request(input logic cmd, input logic [IN_DATA_BITS-1:0] data);
        int gap;
        live_items++;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 5);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic set_window(input int l, input int t, input int r, input int b);
        logic [IN_DATA_BITS-1:0] data;
        data = random_payload();
        data[0 +: COORD_BITS]            = COORD_BITS'(l);
        data[COORD_BITS +: COORD_BITS]   = COORD_BITS'(t);
        data[2*COORD_BITS +: COORD_BITS] = COORD_BITS'(r);
        data[3*COORD_BITS +: COORD_BITS] = COORD_BITS'(b);
        push_request(CMD_SET_WINDOW, data);
    endtask

    task automatic write_pixels(input logic [COLOR_BITS-1:0] color,
                                input logic [COUNT_BITS-1:0] count);
        logic [IN_DATA_BITS-1:0] data;
        data = random_payload();
        data[4*COORD_BITS +: COLOR_BITS]            = color;
        data[4*COORD_BITS+COLOR_BITS +: COUNT_BITS] = count;
        push_request(CMD_WRITE, data);
    endtask

    // Hold the sender until every predicted span has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (spans_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Pick a start and a mostly short extent inside the coordinate range
    task automatic pick_extent(output int lo, output int hi, input int short_max);
        int ext;
        lo = $urandom_range(0, COORD_MAX);
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: ext = $urandom_range(1, short_max);
            5, 6:          ext = $urandom_range(short_max + 1, 400);
            default: begin
                ext = COORD_MAX + 1;
                lo  = ($urandom_range(0, 1) == 1) ? 0 : lo;
            end
        endcase
        hi = (lo + ext - 1 > COORD_MAX) ? COORD_MAX : lo + ext - 1;
    endtask

    initial begin
        int l;
        int t;
        int r;
        int b;
        int kind;
        logic [COUNT_BITS-1:0] count;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window is one pixel at the origin
        write_pixels(32'h0000_0000, 3);
        write_pixels(32'hFFFF_FFFF, 0);
        // full window: one full row, then a count that hits the span limit
        set_window(0, 0, COORD_MAX, COORD_MAX);
        write_pixels(32'h1234_5678, 4096);
        write_pixels(32'hEDCB_A987, 24'hFF_FFFF);
        // one pixel at the far corner
        set_window(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        write_pixels(32'hA5A5_A5A5, 5);
        // small window: wrap at the right edge and past the bottom row
        set_window(10, 20, 12, 21);
        write_pixels(32'h0000_0001, 7);
        write_pixels(32'h0000_0002, 2);
        write_pixels(32'h0000_0003, 0);
        write_pixels(32'h0000_0004, 13);
        // exactly the span limit, then one span too many
        set_window(7, 7, 7, 7);
        write_pixels(32'h0000_0005, 64);
        write_pixels(32'h0000_0006, 65);
        // empty windows, horizontally and vertically
        set_window(100, 0, 99, 10);
        write_pixels(32'h0000_0007, 4);
        set_window(0, 50, 10, 49);
        write_pixels(32'h0000_0008, 4);
        // alternating coordinate bits
        set_window(12'hAAA, 12'h555, 12'hAAF, 12'h556);
        write_pixels(32'h5A5A_5A5A, 20);
        set_window(12'h555, 12'hAAA, 12'h5FF, 12'hAAA);
        write_pixels(32'h8000_0001, 200);
        drain();

        // random traffic: mostly sane windows with writes, some noise
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                pick_extent(l, r, 8);
                pick_extent(t, b, 4);
                set_window(l, t, r, b);
            end else if (kind == 2) begin
                set_window($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: count = COUNT_BITS'($urandom_range(0, 24));
                    6, 7:             count = COUNT_BITS'($urandom_range(25, 600));
                    8:                count = COUNT_BITS'($urandom);
                    default:          count = '0;
                endcase
                write_pixels($urandom, count);
            end
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Stop a run that hangs
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
